FILE: design/cwc_pkg.sv
// Shared constants for the congestion window controller.
package cwc_pkg;

    localparam logic [1:0] MODE_AIMD  = 2'd0;
    localparam logic [1:0] MODE_DELAY = 2'd1;
    localparam logic [1:0] MODE_TREND = 2'd2;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_TICK      = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_DECREMENT = 2'd3;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_SEND = 1'b1;

    localparam int SEQ_BITS  = 32;
    localparam int CFG_BITS  = 16;
    localparam int PROG_BITS = 17;
    localparam logic [PROG_BITS-1:0] PROG_MAX = {PROG_BITS{1'b1}};

    localparam logic [1:0]          RST_MODE      = MODE_TREND;
    localparam logic [CFG_BITS-1:0] RST_TICK      = 16'd20;
    localparam logic [CFG_BITS-1:0] RST_THRESHOLD = 16'd450;
    localparam logic [CFG_BITS-1:0] RST_DECREMENT = 16'd10;

    localparam int RST_CWND = 20;
    localparam int RST_RTT  = 50;
    localparam int RST_SUM  = 50;

endpackage

FILE: design/congestion_window_controller_core.sv
// Congestion window controller: event stream in, window and timeout stream out.
// Each beat on the slave side is one send or ack event and yields exactly one beat on the
// master side carrying the window after that event and a retransmit timeout of twice the
// lowest RTT seen. One event is accepted per clock cycle unless the output stalls; it
// passes the input register, then the update logic feeding the result register. The state
// update's longest path is the RTT-trend mode: min-RTT compare, window gain and the
// multiply-by-reciprocal for the 7/10 or 9/10 periodic decrease. Four APB registers at
// byte addresses 0, 4, 8, 12 hold mode, tick_ms, delay_threshold_ms and delay_decrement;
// the user must write them only while idle, which the block itself does not enforce.
module congestion_window_controller_core
    import cwc_pkg::*;
#(
    parameter int WINDOW_BITS = 16,
    parameter int TIME_BITS   = 32,
    localparam int IN_DW      = SEQ_BITS + 2 * TIME_BITS,
    localparam int IN_DWB     = ((IN_DW + 7) / 8) * 8,
    localparam int OUT_DW     = WINDOW_BITS + TIME_BITS + 1,
    localparam int OUT_DWB    = ((OUT_DW + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // seq_acked, send_time, ack_time
    input  logic [IN_DWB-1:0]  s_axis_tdata,
    // kind, was_timeout
    input  logic [1:0]         s_axis_tuser,

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // window, timeout_value
    output logic [OUT_DWB-1:0] m_axis_tdata,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SHIFT = WINDOW_BITS + 8;
    localparam int MW    = WINDOW_BITS + 9;
    localparam int PW    = WINDOW_BITS + MW;
    localparam int CMPW  = (WINDOW_BITS > PROG_BITS) ? WINDOW_BITS : PROG_BITS;
    localparam int DW    = (WINDOW_BITS > CFG_BITS) ? WINDOW_BITS : CFG_BITS;
    localparam logic [63:0]   RECIP = ((64'd1 << SHIFT) + 64'd9) / 64'd10;
    localparam logic [MW-1:0] MUL7  = MW'(RECIP * 64'd7);
    localparam logic [MW-1:0] MUL9  = MW'(RECIP * 64'd9);
    localparam logic [WINDOW_BITS-1:0] WIN_MAX = {WINDOW_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0]   TIME_MAX = {TIME_BITS{1'b1}};

    logic [1:0]          r_mode;
    logic [CFG_BITS-1:0] r_tick_ms;
    logic [CFG_BITS-1:0] r_threshold;
    logic [CFG_BITS-1:0] r_decrement;

    logic                 r_in_valid;
    logic                 r_in_kind;
    logic                 r_in_timeout;
    logic [SEQ_BITS-1:0]  r_in_seq;
    logic [TIME_BITS-1:0] r_in_send;
    logic [TIME_BITS-1:0] r_in_ack;

    logic                   r_out_valid;
    logic [WINDOW_BITS-1:0] r_out_window;
    logic [TIME_BITS:0]     r_out_timeout;

    logic [WINDOW_BITS-1:0] r_cwnd,       n_cwnd;
    logic [PROG_BITS-1:0]   r_prog,       n_prog;
    logic [SEQ_BITS-1:0]    r_high_ack,   n_high_ack;
    logic [TIME_BITS-1:0]   r_tick_start, n_tick_start;
    logic [TIME_BITS-1:0]   r_lowest_rtt, n_lowest_rtt;
    logic [TIME_BITS-1:0]   r_last_sum,   n_last_sum;
    logic [TIME_BITS-1:0]   r_period_sum, n_period_sum;

    logic advance;
    logic cfg_write;

    logic [TIME_BITS-1:0]   rtt;
    logic                   seq_new;
    logic [PROG_BITS:0]     prog_sum;
    logic [PROG_BITS-1:0]   prog_sat;
    logic                   prog_full;
    logic [WINDOW_BITS:0]   cwnd_inc;
    logic [WINDOW_BITS-1:0] cwnd_plus1;
    logic [DW-1:0]          cwnd_ext;
    logic [DW-1:0]          dec_ext;
    logic [WINDOW_BITS-1:0] cwnd_dec;
    logic [TIME_BITS-1:0]   low_min;
    logic [1:0]             gain;
    logic [WINDOW_BITS:0]   cwnd_gain;
    logic [WINDOW_BITS-1:0] cwnd_grown;
    logic [PW-1:0]          prod;
    logic [WINDOW_BITS:0]   cwnd_cut;
    logic [WINDOW_BITS-1:0] cwnd_cut_sat;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   tick;
    logic [TIME_BITS-1:0]   sum_base;
    logic [TIME_BITS:0]     sum_next;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DWB'({r_out_timeout, r_out_window});
    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:      prdata = 32'(r_mode);
            REG_TICK:      prdata = 32'(r_tick_ms);
            REG_THRESHOLD: prdata = 32'(r_threshold);
            REG_DECREMENT: prdata = 32'(r_decrement);
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= RST_MODE;
            r_tick_ms   <= RST_TICK;
            r_threshold <= RST_THRESHOLD;
            r_decrement <= RST_DECREMENT;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_MODE:      r_mode      <= pwdata[1:0];
                REG_TICK:      r_tick_ms   <= pwdata[CFG_BITS-1:0];
                REG_THRESHOLD: r_threshold <= pwdata[CFG_BITS-1:0];
                REG_DECREMENT: r_decrement <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign rtt     = r_in_ack - r_in_send;
    assign seq_new = r_in_seq > r_high_ack;

    assign prog_sum   = {1'b0, r_prog} + ((r_mode == MODE_AIMD) ? (PROG_BITS+1)'(2)
                                                                : (PROG_BITS+1)'(1));
    assign prog_sat   = prog_sum[PROG_BITS] ? PROG_MAX : prog_sum[PROG_BITS-1:0];
    assign prog_full  = CMPW'(prog_sat) >= CMPW'(r_cwnd);
    assign cwnd_inc   = {1'b0, r_cwnd} + (WINDOW_BITS+1)'(1);
    assign cwnd_plus1 = cwnd_inc[WINDOW_BITS] ? WIN_MAX : cwnd_inc[WINDOW_BITS-1:0];

    assign cwnd_ext = DW'(r_cwnd);
    assign dec_ext  = DW'(r_decrement);
    assign cwnd_dec = (cwnd_ext > dec_ext) ? WINDOW_BITS'(cwnd_ext - dec_ext)
                                           : '0;

    assign low_min = (rtt < r_lowest_rtt) ? rtt : r_lowest_rtt;
    always_comb begin
        priority if (rtt <= r_lowest_rtt) begin
            gain = 2'd2;
        end else if ((rtt - r_lowest_rtt) <= (r_lowest_rtt >> 1)) begin
            gain = 2'd1;
        end else begin
            gain = 2'd0;
        end
    end
    assign cwnd_gain  = {1'b0, r_cwnd} + (WINDOW_BITS+1)'(gain);
    assign cwnd_grown = cwnd_gain[WINDOW_BITS] ? WIN_MAX : cwnd_gain[WINDOW_BITS-1:0];

    assign prod = PW'(cwnd_grown) * PW'((r_period_sum >= r_last_sum) ? MUL7 : MUL9);
    assign cwnd_cut     = {1'b0, prod[SHIFT+WINDOW_BITS-1:SHIFT]} + (WINDOW_BITS+1)'(1);
    assign cwnd_cut_sat = cwnd_cut[WINDOW_BITS] ? WIN_MAX : cwnd_cut[WINDOW_BITS-1:0];

    assign elapsed  = r_in_ack - r_tick_start;
    assign tick     = elapsed >= TIME_BITS'(r_tick_ms);
    assign sum_base = tick ? '0 : r_period_sum;
    assign sum_next = {1'b0, sum_base} + {1'b0, rtt};

    always_comb begin
        n_cwnd       = r_cwnd;
        n_prog       = r_prog;
        n_high_ack   = r_high_ack;
        n_tick_start = r_tick_start;
        n_lowest_rtt = r_lowest_rtt;
        n_last_sum   = r_last_sum;
        n_period_sum = r_period_sum;
        if (r_in_kind == KIND_ACK) begin
            if (seq_new) begin
                n_high_ack = r_in_seq;
            end
            unique case (r_mode)
                MODE_AIMD: begin
                    if (prog_full) begin
                        n_cwnd = cwnd_plus1;
                        n_prog = '0;
                    end else begin
                        n_prog = prog_sat;
                    end
                end
                MODE_DELAY: begin
                    if (rtt < TIME_BITS'(r_threshold) && seq_new) begin
                        if (prog_full) begin
                            n_cwnd = cwnd_plus1;
                            n_prog = '0;
                        end else begin
                            n_prog = prog_sat;
                        end
                    end else begin
                        n_cwnd = cwnd_dec;
                    end
                end
                MODE_TREND: begin
                    n_lowest_rtt = low_min;
                    n_cwnd       = tick ? cwnd_cut_sat : cwnd_grown;
                    if (tick) begin
                        n_tick_start = r_in_ack;
                        n_last_sum   = r_period_sum;
                    end
                    n_period_sum = sum_next[TIME_BITS] ? TIME_MAX : sum_next[TIME_BITS-1:0];
                end
                default: ;
            endcase
        end else if (r_mode == MODE_AIMD && r_in_timeout) begin
            n_cwnd = r_cwnd >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind    <= s_axis_tuser[0];
            r_in_timeout <= s_axis_tuser[1];
            r_in_seq     <= s_axis_tdata[SEQ_BITS-1:0];
            r_in_send    <= s_axis_tdata[SEQ_BITS +: TIME_BITS];
            r_in_ack     <= s_axis_tdata[SEQ_BITS+TIME_BITS +: TIME_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd       <= WINDOW_BITS'(RST_CWND);
            r_prog       <= '0;
            r_high_ack   <= '0;
            r_tick_start <= '0;
            r_lowest_rtt <= TIME_BITS'(RST_RTT);
            r_last_sum   <= TIME_BITS'(RST_SUM);
            r_period_sum <= '0;
        end else if (r_in_valid && advance) begin
            r_cwnd       <= n_cwnd;
            r_prog       <= n_prog;
            r_high_ack   <= n_high_ack;
            r_tick_start <= n_tick_start;
            r_lowest_rtt <= n_lowest_rtt;
            r_last_sum   <= n_last_sum;
            r_period_sum <= n_period_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out_window  <= n_cwnd;
            r_out_timeout <= {n_lowest_rtt, 1'b0};
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input beat accepted while both stages are blocked");

    a_lowest_rtt_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_lowest_rtt <= $past(r_lowest_rtt)))
        else $error("lowest RTT increased");

    a_high_ack_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_high_ack >= $past(r_high_ack)))
        else $error("highest ack decreased");

    a_send_keeps_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in_kind == KIND_SEND && r_mode != MODE_AIMD)
        |=> $stable(r_cwnd))
        else $error("send beat changed the window outside AIMD");

    a_idle_keeps_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_valid && advance) |=> $stable(r_tick_start))
        else $error("tick start moved without an event");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the congestion window controller core.
`timescale 1ns / 1ps

module testbench;
    import cwc_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int NUM_ROWS = 29;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_EVENTS = 48;
    localparam int RIDE_EVENTS = 30;

    typedef enum logic {ROW_EVENT, ROW_WRITE} t_row_op;

    typedef struct packed {
        logic        kind;
        logic [31:0] seq;
        logic [31:0] send_ms;
        logic [31:0] ack_ms;
        logic        was_timeout;
    } t_event;

    typedef struct packed {
        logic [15:0] window;
        logic [32:0] timeout;
    } t_win_result;

    typedef struct packed {
        t_row_op     op;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        t_event      ev;
        logic        pinned;
        t_win_result pinned_res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [1:0]  m_mode = RST_MODE;
    logic [15:0] m_tick = RST_TICK;
    logic [15:0] m_thresh = RST_THRESHOLD;
    logic [15:0] m_decr = RST_DECREMENT;
    logic [15:0] m_cwnd = 16'd20;
    logic [16:0] m_progress = '0;
    logic [31:0] m_high_ack = '0;
    logic [31:0] m_tick_start = '0;
    logic [31:0] m_low_rtt = 32'd50;
    logic [31:0] m_last_sum = 32'd50;
    logic [31:0] m_sum = '0;

    logic [31:0] clock_ms = '0;
    bit          steady = 1'b0;
    int          mismatches = 0;
    t_win_result awaited [$];
    t_row        plan [NUM_ROWS];

    congestion_window_controller_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void grow_window(logic [1:0] n);
        logic [16:0] sum;
        sum = {1'b0, m_cwnd} + n;
        m_cwnd = sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    function automatic void bump_progress(logic [1:0] n);
        logic [17:0] sum;
        sum = {1'b0, m_progress} + n;
        m_progress = (sum > PROG_MAX) ? PROG_MAX : sum[16:0];
        if (m_progress >= m_cwnd) begin
            grow_window(2'd1);
            m_progress = '0;
        end
    endfunction

    function automatic t_win_result advance_window(t_event ev);
        logic [31:0] rtt;
        logic [31:0] since_tick;
        logic [32:0] sum;
        logic [19:0] scaled;
        t_win_result r;
        rtt = ev.ack_ms - ev.send_ms;
        if (ev.kind == KIND_ACK) begin
            case (m_mode)
                MODE_AIMD: bump_progress(2'd2);
                MODE_DELAY: begin
                    if (rtt < {16'h0, m_thresh} && ev.seq > m_high_ack)
                        bump_progress(2'd1);
                    else
                        m_cwnd = (m_cwnd > m_decr) ? m_cwnd - m_decr : 16'd0;
                end
                MODE_TREND: begin
                    if (rtt < m_low_rtt)
                        m_low_rtt = rtt;
                    if (rtt <= m_low_rtt)
                        grow_window(2'd2);
                    else if (rtt - m_low_rtt <= (m_low_rtt >> 1))
                        grow_window(2'd1);
                    since_tick = ev.ack_ms - m_tick_start;
                    if (since_tick >= {16'h0, m_tick}) begin
                        if (m_sum >= m_last_sum)
                            scaled = {4'h0, m_cwnd} * 20'd7;
                        else
                            scaled = {4'h0, m_cwnd} * 20'd9;
                        m_cwnd = 16'(20'd1 + scaled / 20'd10);
                        m_tick_start = ev.ack_ms;
                        m_last_sum = m_sum;
                        m_sum = '0;
                    end
                    sum = {1'b0, m_sum} + {1'b0, rtt};
                    m_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
                default: ;
            endcase
            if (ev.seq > m_high_ack)
                m_high_ack = ev.seq;
        end else if (m_mode == MODE_AIMD && ev.was_timeout) begin
            m_cwnd = m_cwnd >> 1;
        end
        r.window = m_cwnd;
        r.timeout = {m_low_rtt, 1'b0};
        return r;
    endfunction

    function automatic t_event draw_event(bit wild);
        t_event e;
        logic [31:0] rtt;
        e.kind = ($urandom_range(99) < 15) ? KIND_SEND : KIND_ACK;
        e.was_timeout = 1'($urandom_range(1));
        clock_ms += $urandom_range(12);
        case ($urandom_range(9))
            0: rtt = $urandom;
            1: rtt = $urandom_range(70000, 600);
            default: rtt = $urandom_range(120);
        endcase
        e.ack_ms = clock_ms;
        e.send_ms = clock_ms - rtt;
        if ($urandom_range(9) < 8)
            e.seq = m_high_ack + $urandom_range(3, 1);
        else
            e.seq = m_high_ack - $urandom_range(5);
        if (wild) begin
            e.seq = $urandom;
            e.send_ms = $urandom;
            e.ack_ms = $urandom;
        end
        return e;
    endfunction

    function automatic logic [15:0] pick_setting(int unsigned typical_hi);
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(typical_hi));
        endcase
    endfunction

    function automatic t_row ack(logic [31:0] seq, logic [31:0] send_ms, logic [31:0] ack_ms);
        t_row r;
        r = '0;
        r.op = ROW_EVENT;
        r.ev = '{KIND_ACK, seq, send_ms, ack_ms, 1'b0};
        return r;
    endfunction

    function automatic t_row send(logic was_timeout);
        t_row r;
        r = '0;
        r.op = ROW_EVENT;
        r.ev = '{KIND_SEND, 32'h0, 32'h0, 32'h0, was_timeout};
        return r;
    endfunction

    function automatic t_row cfg(logic [1:0] idx, logic [15:0] val);
        t_row r;
        r = '0;
        r.op = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row known(t_row r, logic [15:0] window, logic [32:0] timeout);
        r.pinned = 1'b1;
        r.pinned_res = '{window, timeout};
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
        $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got_v, want_v);
        mismatches++;
    endtask

    task automatic offer_event(t_event ev, logic pinned, t_win_result pinned_res);
        t_win_result r;
        while (!steady && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ev.ack_ms, ev.send_ms, ev.seq};
        s_axis_tuser <= {ev.was_timeout, ev.kind};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        r = advance_window(ev);
        awaited.push_back(pinned ? pinned_res : r);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:      m_mode = val[1:0];
            REG_TICK:      m_tick = val;
            REG_THRESHOLD: m_thresh = val;
            REG_DECREMENT: m_decr = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_win_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited.size() == 0) begin
                flag_mismatch("beat with nothing awaited", 64'(m_axis_tdata), 64'h0);
            end else begin
                want = awaited.pop_front();
                if (m_axis_tdata[15:0] !== want.window)
                    flag_mismatch("window", 64'(m_axis_tdata[15:0]), 64'(want.window));
                if (m_axis_tdata[48:16] !== want.timeout)
                    flag_mismatch("timeout_value", 64'(m_axis_tdata[48:16]),
                                  64'(want.timeout));
            end
        end
        m_axis_tready <= steady || ($urandom_range(99) >= 11);
    end

    initial begin : stimulus
        t_event e;
        logic [1:0] mode_sel;
        plan = '{
            known(send(1'b1), 16'd20, 33'd100),
            known(send(1'b0), 16'd20, 33'd100),
            ack(32'd1, 32'd100, 32'd150),
            ack(32'd2, 32'hFFFF_FFF0, 32'h0000_0010),
            ack(32'd3, 32'h0, 32'hFFFF_FFFF),
            ack(32'd4, 32'd5, 32'd5),
            cfg(REG_TICK, 16'h0000),
            ack(32'd5, 32'd5, 32'd5),
            cfg(REG_TICK, 16'hFFFF),
            ack(32'd6, 32'd5, 32'd10),
            cfg(REG_MODE, {14'h0, MODE_AIMD}),
            ack(32'd7, 32'd10, 32'd20),
            ack(32'd7, 32'd10, 32'd20),
            send(1'b1),
            send(1'b0),
            cfg(REG_MODE, {14'h0, MODE_DELAY}),
            cfg(REG_THRESHOLD, 16'h0000),
            ack(32'd8, 32'd20, 32'd20),
            cfg(REG_THRESHOLD, 16'hFFFF),
            ack(32'd9, 32'd0, 32'd65534),
            ack(32'd9, 32'd0, 32'd1),
            cfg(REG_DECREMENT, 16'h0000),
            ack(32'd8, 32'd0, 32'd0),
            cfg(REG_DECREMENT, 16'hFFFF),
            known(ack(32'd10, 32'd0, 32'd70000), 16'd0, 33'd0),
            ack(32'd11, 32'd0, 32'd1),
            cfg(REG_MODE, {14'h0, MODE_SPARE}),
            ack(32'd12, 32'd0, 32'd3),
            send(1'b1)
        };
        clock_ms = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].op == ROW_WRITE) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                offer_event(plan[i].ev, plan[i].pinned, plan[i].pinned_res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 7) begin
                // ride the window up with zero-RTT acks inside one tick
                settle();
                write_reg(REG_MODE, {14'h0, MODE_TREND});
                write_reg(REG_TICK, 16'hFFFF);
                steady = 1'b1;
                repeat (RIDE_EVENTS) begin
                    e.kind = KIND_ACK;
                    e.seq = $urandom;
                    e.send_ms = m_tick_start;
                    e.ack_ms = m_tick_start;
                    e.was_timeout = 1'($urandom_range(1));
                    offer_event(e, 1'b0, '0);
                end
                steady = 1'b0;
            end
            mode_sel = (p == 8) ? MODE_SPARE : 2'(p % 3);
            settle();
            write_reg(REG_MODE, {14'h0, mode_sel});
            write_reg(REG_TICK, pick_setting(60));
            write_reg(REG_THRESHOLD, pick_setting(150));
            write_reg(REG_DECREMENT, pick_setting(20));
            repeat (PHASE_EVENTS) begin
                e = draw_event($urandom_range(9) == 0);
                offer_event(e, 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && awaited.size() == 0)
            $display("congestion_window_controller_core verification clean");
        else
            $display("congestion_window_controller_core verification failed");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("congestion_window_controller_core verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/cwc_pkg.sv
design/congestion_window_controller_core.sv
tb/testbench.sv
